// ===== rtl/pfr_pkg.sv =====
// Package for the page framebuffer rotator: geometry constants, codes,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps

package pfr_pkg;

	// Source geometry (portrait image)
	localparam int SRC_WIDTH = 64;
	localparam int SRC_PAGES = 16;

	// Store geometry (landscape image)
	localparam int DST_COLS    = SRC_PAGES * 8;
	localparam int DST_PAGES   = (SRC_WIDTH + 7) / 8;
	localparam int STORE_BYTES = DST_PAGES * DST_COLS;

	localparam int SPAGE_W = 4;
	localparam int SCOL_W  = 6;
	localparam int COL_W   = $clog2(DST_COLS);
	localparam int PAGE_W  = $clog2(DST_PAGES);
	localparam int ADDR_W  = $clog2(STORE_BYTES);
	localparam int BIT_W   = 3;

	localparam logic [SPAGE_W-1:0] SPAGE_MAX = SPAGE_W'(SRC_PAGES - 1);
	localparam logic [SCOL_W-1:0]  SCOL_MAX  = SCOL_W'(SRC_WIDTH - 1);
	localparam logic [SCOL_W-1:0]  ROW_LAST  = SCOL_W'(SRC_WIDTH - 1);
	localparam logic [COL_W-1:0]   COL_LAST  = COL_W'(DST_COLS - 1);
	localparam logic [PAGE_W-1:0]  PAGE_LAST = PAGE_W'(DST_PAGES - 1);
	localparam logic [ADDR_W-1:0]  ADDR_LAST = ADDR_W'(STORE_BYTES - 1);
	localparam logic [BIT_W-1:0]   BIT_LAST  = BIT_W'(7);

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_LEFT  = 2'd1,
		MODE_RIGHT = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAT,
		ST_DRAIN,
		ST_CLR,
		ST_RD,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic              capture;   // latch the input item fields
		logic              scat_rd;   // read one scatter target byte
		logic [BIT_W-1:0]  bit_idx;   // source bit being scattered
		logic              host_rd;   // read the requested store byte
		logic              clr_wr;    // write zero during a clear sweep
		logic [ADDR_W-1:0] clr_addr;
		logic              load_out;  // move read data to the output register
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       out_busy;         // output register full and stalled
	} stat_t;

endpackage

// ===== rtl/pfr_dpath.sv =====
// Datapath of the page framebuffer rotator: field capture, address mapping,
// the 1024-byte store with its read-modify-write pipe, and the output register.
// Depends on pfr_pkg.
`timescale 1ns / 1ps

module pfr_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfr_pkg::cmd_t                 cmd,
	output pfr_pkg::stat_t                stat,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_wdata,
	input  logic [pfr_pkg::SPAGE_W-1:0]   src_page,
	input  logic [pfr_pkg::SCOL_W-1:0]    src_column,
	input  logic [7:0]                    pixel_byte,
	input  logic [pfr_pkg::PAGE_W-1:0]    rd_page,
	input  logic [pfr_pkg::COL_W-1:0]     rd_column,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [7:0]                    read_data
);

	logic [1:0]                  mode_q;
	logic [pfr_pkg::SPAGE_W-1:0] sp_q;
	logic [pfr_pkg::SCOL_W-1:0]  sc_q;
	logic [7:0]                  pix_q;
	logic [pfr_pkg::PAGE_W-1:0]  rp_q;
	logic [pfr_pkg::COL_W-1:0]   rc_q;

	logic [7:0] mem [pfr_pkg::STORE_BYTES];
	logic [7:0] rdata_q;

	logic [pfr_pkg::COL_W-1:0]  y;
	logic [pfr_pkg::COL_W-1:0]  tcol;
	logic [pfr_pkg::SCOL_W-1:0] trow;
	logic [pfr_pkg::ADDR_W-1:0] taddr;
	logic [pfr_pkg::ADDR_W-1:0] rd_addr;
	logic                       rd_en;

	logic                       wr_s1;
	logic [pfr_pkg::ADDR_W-1:0] waddr_s1;
	logic [pfr_pkg::BIT_W-1:0]  wbit_s1;
	logic                       wpix_s1;

	logic                       we;
	logic [pfr_pkg::ADDR_W-1:0] wa;
	logic [7:0]                 wd;
	logic [7:0]                 mask;

	logic       out_valid_q;
	logic [7:0] read_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pfr_pkg::MODE_NONE;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Capture the item, saturating out-of-range coordinates
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sp_q  <= (src_page > pfr_pkg::SPAGE_MAX) ? pfr_pkg::SPAGE_MAX : src_page;
			sc_q  <= (src_column > pfr_pkg::SCOL_MAX) ? pfr_pkg::SCOL_MAX : src_column;
			pix_q <= pixel_byte;
			rp_q  <= (rd_page > pfr_pkg::PAGE_LAST) ? pfr_pkg::PAGE_LAST : rd_page;
			rc_q  <= (rd_column > pfr_pkg::COL_LAST) ? pfr_pkg::COL_LAST : rd_column;
		end
	end

	// Target of source bit: left -> (y, 63-x), right -> (127-y, x)
	always_comb begin
		y = {sp_q, cmd.bit_idx};
		if (mode_q == pfr_pkg::MODE_LEFT) begin
			tcol = y;
			trow = pfr_pkg::ROW_LAST - sc_q;
		end else begin
			tcol = pfr_pkg::COL_LAST - y;
			trow = sc_q;
		end
		taddr = {trow[pfr_pkg::SCOL_W-1:pfr_pkg::BIT_W], tcol};
	end

	assign rd_en   = cmd.scat_rd | cmd.host_rd;
	assign rd_addr = cmd.scat_rd ? taddr : {rp_q, rc_q};

	// Write stage is registered from the read and follows it in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= cmd.scat_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scat_rd) begin
			waddr_s1 <= taddr;
			wbit_s1  <= trow[pfr_pkg::BIT_W-1:0];
			wpix_s1  <= pix_q[cmd.bit_idx];
		end
	end

	always_comb begin
		mask = 8'd1 << wbit_s1;
		we   = wr_s1 | cmd.clr_wr;
		wa   = cmd.clr_wr ? cmd.clr_addr : waddr_s1;
		if (cmd.clr_wr) begin
			wd = 8'd0;
		end else if (wpix_s1) begin
			wd = rdata_q | mask;
		end else begin
			wd = rdata_q & ~mask;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Output register: holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_data_q <= rdata_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = read_data_q;
	assign stat.mode     = mode_q;
	assign stat.out_busy = out_valid_q & out_stall;

endmodule

// ===== rtl/pfr_ctrl.sv =====
// Controller of the page framebuffer rotator: sequences scatter, read and
// clear items and the clearing pass after reset. Depends on pfr_pkg.
`timescale 1ns / 1ps

module pfr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     kind,
	output logic           in_stall,
	input  pfr_pkg::stat_t stat,
	output pfr_pkg::cmd_t  cmd
);

	pfr_pkg::state_t state_q, state_d;
	logic [pfr_pkg::ADDR_W-1:0] cnt_q;
	logic                       rot_on;

	assign rot_on = (stat.mode == pfr_pkg::MODE_LEFT) || (stat.mode == pfr_pkg::MODE_RIGHT);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfr_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (kind)
						pfr_pkg::KIND_WRITE: state_d = rot_on ? pfr_pkg::ST_SCAT
							: pfr_pkg::ST_IDLE;
						pfr_pkg::KIND_READ:  state_d = pfr_pkg::ST_RD;
						pfr_pkg::KIND_CLEAR: state_d = pfr_pkg::ST_CLR;
						default:             state_d = pfr_pkg::ST_IDLE;
					endcase
				end
			end
			pfr_pkg::ST_SCAT: begin
				if (cnt_q[pfr_pkg::BIT_W-1:0] == pfr_pkg::BIT_LAST) begin
					state_d = pfr_pkg::ST_DRAIN;
				end
			end
			pfr_pkg::ST_DRAIN: state_d = pfr_pkg::ST_IDLE;
			pfr_pkg::ST_CLR: begin
				if (cnt_q == pfr_pkg::ADDR_LAST) begin
					state_d = pfr_pkg::ST_IDLE;
				end
			end
			pfr_pkg::ST_RD:   state_d = pfr_pkg::ST_LOAD;
			pfr_pkg::ST_LOAD: begin
				if (!stat.out_busy) begin
					state_d = pfr_pkg::ST_IDLE;
				end
			end
			default: state_d = pfr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfr_pkg::ST_CLR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == pfr_pkg::ST_SCAT || state_q == pfr_pkg::ST_CLR)
					&& state_d == state_q) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.bit_idx  = cnt_q[pfr_pkg::BIT_W-1:0];
		cmd.clr_addr = cnt_q;
		in_stall     = 1'b1;
		unique case (state_q)
			pfr_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			pfr_pkg::ST_SCAT:  cmd.scat_rd  = 1'b1;
			pfr_pkg::ST_DRAIN: ;
			pfr_pkg::ST_CLR:   cmd.clr_wr   = 1'b1;
			pfr_pkg::ST_RD:    cmd.host_rd  = 1'b1;
			pfr_pkg::ST_LOAD:  cmd.load_out = !stat.out_busy;
			default: ;
		endcase
	end

endmodule

// ===== rtl/page_framebuffer_rotator_unit.sv =====
// Top level of the page framebuffer rotator: ties controller and datapath.
// Depends on pfr_pkg, pfr_ctrl and pfr_dpath.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): one item per handshake, kind selects
//   write source byte, read store byte or clear store. An item is taken on a
//   rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): one read_data item per read item.
//   Configuration: cfg_we / cfg_wdata write rotation_mode; write it only while
//   the block is idle.
// Timing
//   Write item: accept, eight read-modify-write reads of a store with one
//   read and one write port, one drain write; each source bit lands in its
//   own store byte, so the scatter loop sets the item's length.
//   Read item: the store byte is read, then moved to the output register,
//   which waits while a stalled result is held; the next item follows. Clear
//   item: every store byte is written to zero, one byte written per cycle.
// Reset
//   After arst_n rises the store is swept to zero with in_stall high;
//   configuration writes are taken meanwhile.
// Back-pressure
//   A stalled result holds in the output register while write and clear
//   items go on; a further read item waits until that result is taken.

module page_framebuffer_rotator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  kind,
	input  logic [pfr_pkg::SPAGE_W-1:0] src_page,
	input  logic [pfr_pkg::SCOL_W-1:0]  src_column,
	input  logic [7:0]                  pixel_byte,
	input  logic [pfr_pkg::PAGE_W-1:0]  rd_page,
	input  logic [pfr_pkg::COL_W-1:0]   rd_column,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  read_data
);

	pfr_pkg::cmd_t  cmd;
	pfr_pkg::stat_t stat;

	// Sequence items and the reset sweep
	pfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold the store, map pixels and drive the result
	pfr_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.src_page   (src_page),
		.src_column (src_column),
		.pixel_byte (pixel_byte),
		.rd_page    (rd_page),
		.rd_column  (rd_column),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.read_data  (read_data)
	);

endmodule
